// ===== hdl/sync_seq_crc32_frame_checker_core_macros.svh =====
`ifndef SYNC_SEQ_CRC32_FRAME_CHECKER_CORE_MACROS_SVH
`define SYNC_SEQ_CRC32_FRAME_CHECKER_CORE_MACROS_SVH

`ifndef SYNTH
`define SSCC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define SSCC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SSCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSCC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define SSCC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define SSCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/sscc_pkg.sv =====
`default_nettype none
package sscc_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [23:0] SYNC_HEAD3 = 24'hA55A5A;
	localparam logic [7:0] SYNC_B0 = 8'hA5;
	localparam logic [7:0] SYNC_B1 = 8'h5A;
	localparam logic [15:0] PAYLOAD_LEN_RST = 16'd4096;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		ST_GOOD = 2'd0,
		ST_CRC_BAD = 2'd1,
		ST_HDR_BAD = 2'd2
	} frame_status_t;

	typedef enum logic {
		EVT_RESYNC = 1'b0,
		EVT_FRAME = 1'b1
	} evt_kind_t;

	typedef struct packed {
		evt_kind_t kind;
		frame_status_t status;
		logic [31:0] seq;
	} sscc_evt_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] sync_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = SYNC_B0;
			2'd1: r = SYNC_B1;
			2'd2: r = SYNC_B1;
			default: r = SYNC_B0;
		endcase
		return r;
	endfunction

	localparam logic [31:0] SYNC_CRC =
		crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, SYNC_B0), SYNC_B1), SYNC_B1), SYNC_B0);

endpackage
`default_nettype wire

// ===== hdl/sscc_front.sv =====
`default_nettype none
module sscc_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [15:0] payload_len,
	input  wire logic q_full,
	output logic push,
	output sscc_pkg::sscc_evt_t push_evt
);
	import sscc_pkg::*;

	typedef enum logic [1:0] {
		S_HUNT = 2'b01,
		S_LOCK = 2'b10
	} front_state_t;

	front_state_t state_q;
	logic [15:0] payload_len_q;
	logic [23:0] hunt_window_q;
	logic [2:0] hunt_count_q;
	logic [16:0] byte_index_q;
	logic header_good_q;
	logic [31:0] running_crc_q;
	logic [31:0] seq_shift_q;
	logic [31:0] rx_crc_shift_q;

	logic accept;
	logic [16:0] frame_bytes;
	logic [16:0] crc_end;
	logic [17:0] idx_inc;
	logic last;
	logic hunt_hit;
	logic [31:0] rx_crc_next;
	logic [31:0] crc_next;
	logic crc_ok;

	assign cfg_ready = 1'b1;
	assign in_stall = q_full;
	assign accept = in_valid && !in_stall;

	assign frame_bytes = {1'b0, payload_len_q} + 17'd12;
	assign crc_end = {1'b0, payload_len_q} + 17'd8;
	assign idx_inc = {1'b0, byte_index_q} + 18'd1;
	assign last = idx_inc >= {1'b0, frame_bytes};
	assign hunt_hit = (hunt_count_q >= 3'd3) && (hunt_window_q == SYNC_HEAD3)
		&& (rx_byte == SYNC_B0);
	assign rx_crc_next = {rx_byte, rx_crc_shift_q[31:8]};
	assign crc_next = crc_byte(running_crc_q, rx_byte);
	assign crc_ok = (running_crc_q ^ CRC_INIT) == rx_crc_next;

	always_comb begin
		push = 1'b0;
		push_evt.kind = EVT_FRAME;
		push_evt.status = ST_GOOD;
		push_evt.seq = seq_shift_q;
		case (state_q)
			S_HUNT: begin
				if (accept && hunt_hit && hunt_count_q >= 3'd4) begin
					push = 1'b1;
					push_evt.kind = EVT_RESYNC;
				end
			end
			S_LOCK: begin
				if (accept && last) begin
					push = 1'b1;
					if (!header_good_q) begin
						push_evt.status = ST_HDR_BAD;
					end else if (crc_ok) begin
						push_evt.status = ST_GOOD;
					end else begin
						push_evt.status = ST_CRC_BAD;
					end
				end
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_len_q <= PAYLOAD_LEN_RST;
		end else if (cfg_valid) begin
			payload_len_q <= payload_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
			hunt_window_q <= '0;
			hunt_count_q <= '0;
			byte_index_q <= '0;
			header_good_q <= 1'b1;
			running_crc_q <= CRC_INIT;
			seq_shift_q <= '0;
			rx_crc_shift_q <= '0;
		end else if (accept) begin
			case (state_q)
				S_HUNT: begin
					if (hunt_hit) begin
						state_q <= S_LOCK;
						hunt_window_q <= '0;
						hunt_count_q <= '0;
						byte_index_q <= 17'd4;
						header_good_q <= 1'b1;
						running_crc_q <= SYNC_CRC;
					end else begin
						hunt_window_q <= {hunt_window_q[15:0], rx_byte};
						if (hunt_count_q < 3'd4) begin
							hunt_count_q <= hunt_count_q + 3'd1;
						end
					end
				end
				S_LOCK: begin
					if (byte_index_q < 17'd4 && rx_byte != sync_byte(byte_index_q[1:0])) begin
						header_good_q <= 1'b0;
					end
					if (byte_index_q >= 17'd4 && byte_index_q < 17'd8) begin
						seq_shift_q <= {rx_byte, seq_shift_q[31:8]};
					end
					if (byte_index_q < crc_end) begin
						running_crc_q <= crc_next;
					end else begin
						rx_crc_shift_q <= rx_crc_next;
					end
					if (!last) begin
						byte_index_q <= idx_inc[16:0];
					end else begin
						byte_index_q <= '0;
						header_good_q <= 1'b1;
						running_crc_q <= CRC_INIT;
						if (!header_good_q || !crc_ok) begin
							state_q <= S_HUNT;
							hunt_window_q <= '0;
							hunt_count_q <= '0;
						end
					end
				end
				default: state_q <= S_HUNT;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/sscc_fifo.sv =====
`default_nettype none
`include "sync_seq_crc32_frame_checker_core_macros.svh"
module sscc_fifo #(
	parameter int DEPTH = sscc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire sscc_pkg::sscc_evt_t push_evt,
	input  wire logic pop,
	output sscc_pkg::sscc_evt_t pop_evt,
	output logic full,
	output logic empty
);
	import sscc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sscc_evt_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign pop_evt = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_adv(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_adv(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SSCC_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full, "push into full queue")
	`SSCC_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty, "pop from empty queue")
	`SSCC_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, !empty, "queue empty after push")

endmodule
`default_nettype wire

// ===== hdl/sscc_back.sv =====
`default_nettype none
module sscc_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire sscc_pkg::sscc_evt_t q_evt,
	output logic pop,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [1:0] frame_status,
	output logic [31:0] frame_seq,
	output logic seq_error,
	output logic [31:0] next_expected_seq,
	output logic [31:0] total_frames,
	output logic [31:0] good_frames,
	output logic [31:0] crc_errors,
	output logic [31:0] seq_errors,
	output logic [31:0] resyncs
);
	import sscc_pkg::*;

	logic out_valid_q;
	frame_status_t status_q;
	logic [31:0] frame_seq_q;
	logic seq_error_q;
	logic [31:0] expected_seq_q;
	logic [31:0] count_total_q;
	logic [31:0] count_good_q;
	logic [31:0] count_crc_bad_q;
	logic [31:0] count_seq_bad_q;
	logic [31:0] count_resync_q;
	logic seq_mismatch;

	assign pop = !q_empty && (!out_valid_q || !out_stall);
	assign seq_mismatch = q_evt.seq != expected_seq_q;

	assign out_valid = out_valid_q;
	assign frame_status = status_q;
	assign frame_seq = frame_seq_q;
	assign seq_error = seq_error_q;
	assign next_expected_seq = expected_seq_q;
	assign total_frames = count_total_q;
	assign good_frames = count_good_q;
	assign crc_errors = count_crc_bad_q;
	assign seq_errors = count_seq_bad_q;
	assign resyncs = count_resync_q;

	always_ff @(posedge clk) begin
		if (pop && q_evt.kind == EVT_FRAME) begin
			status_q <= q_evt.status;
			frame_seq_q <= q_evt.seq;
			seq_error_q <= (q_evt.status != ST_HDR_BAD) && seq_mismatch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			expected_seq_q <= '0;
			count_total_q <= '0;
			count_good_q <= '0;
			count_crc_bad_q <= '0;
			count_seq_bad_q <= '0;
			count_resync_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				case (q_evt.kind)
					EVT_RESYNC: begin
						count_resync_q <= count_resync_q + 32'd1;
					end
					EVT_FRAME: begin
						out_valid_q <= 1'b1;
						if (q_evt.status != ST_HDR_BAD) begin
							count_total_q <= count_total_q + 32'd1;
							if (seq_mismatch) begin
								count_seq_bad_q <= count_seq_bad_q + 32'd1;
								expected_seq_q <= q_evt.seq + 32'd1;
							end else begin
								expected_seq_q <= expected_seq_q + 32'd1;
							end
							if (q_evt.status == ST_GOOD) begin
								count_good_q <= count_good_q + 32'd1;
							end else begin
								count_crc_bad_q <= count_crc_bad_q + 32'd1;
							end
						end
					end
					default: out_valid_q <= out_valid_q;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/sync_seq_crc32_frame_checker_core.sv =====
// Channel   Handshake           Payload
// in        in_valid/in_stall   rx_byte[7:0]
// cfg       cfg_valid/cfg_ready payload_len[15:0]
// out       out_valid/out_stall frame_status, frame_seq, seq_error, next_expected_seq, counters
//
// One byte per cycle while in_stall is low; the front framer updates CRC and framing state in the cycle of the beat.
// After the last beat of its frame, a result passes through the event queue, then the output register.
// in_stall rises only while the event queue holds QUEUE_DEPTH entries.
// Reset is asynchronous: hunting, payload_len 4096, all counters zero.
`default_nettype none
module sync_seq_crc32_frame_checker_core #(
	parameter int QUEUE_DEPTH = sscc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [15:0] payload_len,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [1:0] frame_status,
	output logic [31:0] frame_seq,
	output logic seq_error,
	output logic [31:0] next_expected_seq,
	output logic [31:0] total_frames,
	output logic [31:0] good_frames,
	output logic [31:0] crc_errors,
	output logic [31:0] seq_errors,
	output logic [31:0] resyncs
);
	import sscc_pkg::*;

	logic push;
	sscc_evt_t push_evt;
	logic pop;
	sscc_evt_t pop_evt;
	logic q_full;
	logic q_empty;

	sscc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.payload_len(payload_len),
		.q_full(q_full),
		.push(push),
		.push_evt(push_evt)
	);

	sscc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_evt(push_evt),
		.pop(pop),
		.pop_evt(pop_evt),
		.full(q_full),
		.empty(q_empty)
	);

	sscc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_evt(pop_evt),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_status(frame_status),
		.frame_seq(frame_seq),
		.seq_error(seq_error),
		.next_expected_seq(next_expected_seq),
		.total_frames(total_frames),
		.good_frames(good_frames),
		.crc_errors(crc_errors),
		.seq_errors(seq_errors),
		.resyncs(resyncs)
	);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

import sscc_pkg::*;

localparam logic [31:0] SYNC_WORD = {SYNC_B0, SYNC_B1, SYNC_B1, SYNC_B0};

typedef struct {
	frame_status_t status;
	logic [31:0] seq;
	logic seq_err;
	logic [31:0] seq_next;
	logic [31:0] total;
	logic [31:0] good;
	logic [31:0] crc_bad;
	logic [31:0] seq_bad;
	logic [31:0] resync;
} frame_report_t;

function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] data);
	logic [31:0] c;
	int k;
	c = crc;
	for (k = 0; k < 8; k++) begin
		if (c[0] ^ data[k])
			c = (c >> 1) ^ CRC_POLY;
		else
			c = c >> 1;
	end
	return c;
endfunction

class frame_tracker;
	frame_report_t expected_reports[$];
	int errors;
	logic [15:0] frame_payload;
	bit in_frame;
	logic [23:0] hunt_win;
	int hunt_seen;
	int pos;
	bit hdr_ok;
	logic [31:0] crc_acc;
	logic [31:0] seq_acc;
	logic [31:0] crc_rx;
	logic [31:0] seq_want;
	logic [31:0] n_total;
	logic [31:0] n_good;
	logic [31:0] n_crc_bad;
	logic [31:0] n_seq_bad;
	logic [31:0] n_resync;

	function new();
		errors = 0;
		frame_payload = 16'd4096;
		in_frame = 0;
		hunt_win = '0;
		hunt_seen = 0;
		pos = 0;
		hdr_ok = 1;
		crc_acc = CRC_INIT;
		seq_acc = '0;
		crc_rx = '0;
		seq_want = '0;
		n_total = '0;
		n_good = '0;
		n_crc_bad = '0;
		n_seq_bad = '0;
		n_resync = '0;
	endfunction

	function void restart_hunt();
		in_frame = 0;
		hunt_win = '0;
		hunt_seen = 0;
	endfunction

	function void take_byte(logic [7:0] b);
		frame_report_t r;
		int crc_end;
		int frame_bytes;
		int i;
		if (!in_frame) begin
			if (hunt_seen >= 3 && hunt_win == SYNC_WORD[31:8] && b == SYNC_WORD[7:0]) begin
				if (hunt_seen >= 4)
					n_resync++;
				restart_hunt();
				in_frame = 1;
				hdr_ok = 1;
				crc_acc = CRC_INIT;
				for (i = 0; i < 4; i++)
					crc_acc = crc32_step(crc_acc, SYNC_WORD[31 - 8*i -: 8]);
				pos = 4;
			end else begin
				hunt_win = {hunt_win[15:0], b};
				if (hunt_seen < 4)
					hunt_seen++;
			end
			return;
		end

		crc_end = frame_payload + 8;
		frame_bytes = frame_payload + 12;
		if (pos < 4) begin
			if (b != SYNC_WORD[31 - 8*pos -: 8])
				hdr_ok = 0;
		end else if (pos < 8) begin
			seq_acc = {b, seq_acc[31:8]};
		end
		if (pos < crc_end)
			crc_acc = crc32_step(crc_acc, b);
		else
			crc_rx = {b, crc_rx[31:8]};
		if (pos + 1 < frame_bytes) begin
			pos++;
			return;
		end

		r.seq_err = 0;
		if (!hdr_ok) begin
			r.status = ST_HDR_BAD;
			restart_hunt();
		end else begin
			if (seq_acc != seq_want) begin
				r.seq_err = 1;
				n_seq_bad++;
				seq_want = seq_acc + 1;
			end else begin
				seq_want++;
			end
			n_total++;
			if ((crc_acc ^ CRC_INIT) == crc_rx) begin
				r.status = ST_GOOD;
				n_good++;
			end else begin
				r.status = ST_CRC_BAD;
				n_crc_bad++;
				restart_hunt();
			end
		end
		pos = 0;
		hdr_ok = 1;
		crc_acc = CRC_INIT;

		r.seq = seq_acc;
		r.seq_next = seq_want;
		r.total = n_total;
		r.good = n_good;
		r.crc_bad = n_crc_bad;
		r.seq_bad = n_seq_bad;
		r.resync = n_resync;
		expected_reports.insert(expected_reports.size(), r);
	endfunction

	function void compare(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			errors++;
		end
	endfunction

	function void match_report(frame_report_t got);
		frame_report_t want;
		if (expected_reports.size() == 0) begin
			$display("%0t: unexpected frame report, expected none, actual status %h seq %h",
				$time, got.status, got.seq);
			errors++;
			return;
		end
		want = expected_reports[0];
		expected_reports.delete(0);
		compare("frame_status", want.status, got.status);
		compare("frame_seq", want.seq, got.seq);
		compare("seq_error", want.seq_err, got.seq_err);
		compare("next_expected_seq", want.seq_next, got.seq_next);
		compare("total_frames", want.total, got.total);
		compare("good_frames", want.good, got.good);
		compare("crc_errors", want.crc_bad, got.crc_bad);
		compare("seq_errors", want.seq_bad, got.seq_bad);
		compare("resyncs", want.resync, got.resync);
	endfunction
endclass

module testbench;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 6;

	typedef enum int {
		FK_GOOD,
		FK_BAD_CRC,
		FK_BAD_HDR
	} frame_kind_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] rx_byte;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] payload_len;
	logic out_valid;
	logic out_stall;
	logic [1:0] frame_status;
	logic [31:0] frame_seq;
	logic seq_error;
	logic [31:0] next_expected_seq;
	logic [31:0] total_frames;
	logic [31:0] good_frames;
	logic [31:0] crc_errors;
	logic [31:0] seq_errors;
	logic [31:0] resyncs;

	frame_tracker tracker = new();
	frame_report_t seen;
	logic [7:0] tx_q[$];
	bit tx_busy = 0;
	int snd_idle = 0;
	int rcv_idle = 0;
	int reports_seen = 0;
	bit held_off = 0;
	int quiet_cycles = 0;
	logic [31:0] gen_seq;

	sync_seq_crc32_frame_checker_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.payload_len(payload_len),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_status(frame_status),
		.frame_seq(frame_seq),
		.seq_error(seq_error),
		.next_expected_seq(next_expected_seq),
		.total_frames(total_frames),
		.good_frames(good_frames),
		.crc_errors(crc_errors),
		.seq_errors(seq_errors),
		.resyncs(resyncs)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && in_valid && !in_stall) begin
				tracker.take_byte(rx_byte);
				tx_busy = 0;
			end
			@(negedge clk);
			if (!tx_busy) begin
				if (arst_n && tx_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
					in_valid <= 1;
					rx_byte <= tx_q[0];
					tx_q.delete(0);
					tx_busy = 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (!held_off && reports_seen >= 8) begin
				held_off = 1;
				out_stall <= 1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < rcv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.status = frame_status_t'(frame_status);
			seen.seq = frame_seq;
			seen.seq_err = seq_error;
			seen.seq_next = next_expected_seq;
			seen.total = total_frames;
			seen.good = good_frames;
			seen.crc_bad = crc_errors;
			seen.seq_bad = seq_errors;
			seen.resync = resyncs;
			tracker.match_report(seen);
			reports_seen++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] link_byte();
		case ($urandom_range(7))
			0: return SYNC_B0;
			1: return SYNC_B1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic wait_drained();
		while (tx_q.size() != 0 || tx_busy)
			@(posedge clk);
		while (tracker.expected_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_payload_len(input logic [15:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1;
		payload_len <= v;
		do @(posedge clk); while (!cfg_ready);
		tracker.frame_payload = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// pad a frame left open to its end under the current length
	task automatic finish_open_frame();
		wait_drained();
		if (tracker.in_frame && tracker.pos != 0)
			repeat (tracker.frame_payload + 12 - tracker.pos) tx_q.insert(tx_q.size(), 8'h00);
	endtask

	task automatic queue_frame(input int len, input logic [31:0] seq, input frame_kind_t kind,
			input int keep);
		logic [7:0] body[$];
		logic [31:0] crc;
		int i;
		int j;
		for (i = 0; i < 4; i++)
			body.insert(body.size(), SYNC_WORD[31 - 8*i -: 8]);
		if (kind == FK_BAD_HDR) begin
			j = $urandom_range(3);
			body[j] = body[j] ^ (8'h01 << $urandom_range(7));
		end
		for (i = 0; i < 4; i++)
			body.insert(body.size(), seq[8*i +: 8]);
		for (i = 0; i < len; i++)
			body.insert(body.size(), link_byte());
		crc = CRC_INIT;
		for (i = 0; i < body.size(); i++)
			crc = crc32_step(crc, body[i]);
		crc = crc ^ CRC_INIT;
		if (kind == FK_BAD_CRC) begin
			j = $urandom_range(31);
			crc[j] = ~crc[j];
		end
		for (i = 0; i < 4; i++)
			body.insert(body.size(), crc[8*i +: 8]);
		if (keep == 0)
			keep = body.size();
		for (i = 0; i < keep; i++)
			tx_q.insert(tx_q.size(), body[i]);
	endtask

	task automatic random_frames(input int len, input int n_items);
		int sent;
		int r;
		int k;
		int keep;
		frame_kind_t kind;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 10) begin
				k = $urandom_range(6, 1);
				repeat (k) tx_q.insert(tx_q.size(), link_byte());
				sent += k;
			end
			r = $urandom_range(99);
			if (r < 80)
				kind = FK_GOOD;
			else if (r < 91)
				kind = FK_BAD_CRC;
			else
				kind = FK_BAD_HDR;
			r = $urandom_range(99);
			if (r < 6)
				gen_seq = $urandom;
			else if (r < 9)
				gen_seq = '1;
			keep = ($urandom_range(99) < 5) ? $urandom_range(len + 11, 1) : 0;
			queue_frame(len, gen_seq, kind, keep);
			gen_seq++;
			sent += (keep == 0) ? len + 12 : keep;
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		rx_byte = '0;
		cfg_valid = 0;
		payload_len = '0;
		out_stall = 0;
		gen_seq = '0;
		snd_idle = 6;
		rcv_idle = 64;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// open a frame at the reset length, then end it early by shrinking
		queue_frame(64, gen_seq, FK_GOOD, 40);
		write_payload_len(16'd0);

		tx_q.insert(tx_q.size(), 8'hFF);
		queue_frame(0, 32'hFFFF_FFFF, FK_GOOD, 0);
		queue_frame(0, 32'h0000_0000, FK_BAD_HDR, 0);
		gen_seq = '0;

		random_frames(0, 180);
		wait_drained();
		random_frames(0, 180);
		write_payload_len(16'd5);
		random_frames(5, 260);

		// change length with a frame open, growing it
		finish_open_frame();
		queue_frame(5, gen_seq, FK_GOOD, 10);
		gen_seq++;
		write_payload_len(16'd13);
		snd_idle = 64;
		rcv_idle = 6;
		random_frames(13, 260);

		// shrink length below the open frame's position
		finish_open_frame();
		queue_frame(13, gen_seq, FK_GOOD, 20);
		gen_seq++;
		write_payload_len(16'd2);
		random_frames(2, 260);

		snd_idle = 0;
		rcv_idle = 0;
		finish_open_frame();
		write_payload_len(16'hFFFF);
		queue_frame(64, gen_seq, FK_GOOD, 40);
		gen_seq++;
		write_payload_len(16'd1);
		random_frames(1, 300);

		wait_drained();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_reports.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sscc_pkg.sv
hdl/sscc_front.sv
hdl/sscc_fifo.sv
hdl/sscc_back.sv
hdl/sync_seq_crc32_frame_checker_core.sv
tb/testbench.sv
